/* rtl/k_means_clustering_engine_assert.svh */
// Assertion macros for the k-means clustering engine checker.
`ifndef K_MEANS_CLUSTERING_ENGINE_ASSERT_SVH
`define K_MEANS_CLUSTERING_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define KMCE_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define KMCE_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/kmce_pkg.sv */
// Shared types and constants for the k-means clustering engine.
`default_nettype none
package kmce_pkg;

    localparam int COORD_FIELD_W = 16;
    localparam int NUM_COORD_FIELDS = 4;
    localparam int PASS_W = 16;
    localparam logic [PASS_W-1:0] PASS_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        REG_DIMS_IN_USE = 2'd0,
        REG_ITER_MODE   = 2'd1,
        REG_ITER_LIMIT  = 2'd2
    } kmce_reg_e;

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_RUN  = 1'b1
    } kmce_func_e;

    typedef struct packed {
        logic [2:0]  dims_in_use;
        logic        iteration_mode;
        logic [15:0] iteration_limit;
    } kmce_cfg_t;

    typedef struct packed {
        logic        last;
        logic [15:0] passes_done;
        logic [2:0]  cluster;
        logic [5:0]  point_index;
    } kmce_res_t;

endpackage
`default_nettype wire

/* rtl/kmce_div.sv */
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module kmce_div #(
    parameter int NUM_BITS = 22,
    parameter int DEN_BITS = 7
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic signed [NUM_BITS-1:0] num,
    input  wire logic [DEN_BITS-1:0]        den,
    output logic                            done,
    output logic signed [NUM_BITS-1:0]      quot
);
    localparam int CNT_W = $clog2(NUM_BITS + 1);

    logic [DEN_BITS:0]   rem_reg, rem_next;
    logic [NUM_BITS-1:0] quo_reg, quo_next;
    logic [DEN_BITS-1:0] den_reg, den_next;
    logic                neg_reg, neg_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                run_reg, run_next;
    logic                done_reg, done_next;
    logic [DEN_BITS:0]   shifted;
    logic                fits;

    always_comb
    begin
        shifted   = {rem_reg[DEN_BITS-1:0], quo_reg[NUM_BITS-1]};
        fits      = (shifted >= {1'b0, den_reg});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = num[NUM_BITS-1] ? (~num + 1'b1) : num;
            den_next = den;
            neg_next = num[NUM_BITS-1];
            cnt_next = CNT_W'(NUM_BITS);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = fits ? (shifted - {1'b0, den_reg}) : shifted;
            quo_next = {quo_reg[NUM_BITS-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quot = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule
`default_nettype wire

/* rtl/kmce_core.sv */
// Point and label memories, center and sum registers, and the Lloyd pass sequencer.
`default_nettype none
module kmce_core #(
    parameter int CLUSTERS   = 4,
    parameter int DIMS       = 4,
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire kmce_pkg::kmce_cfg_t          cfg,
    input  wire logic                         in_valid,
    input  wire logic                         in_func,
    input  wire logic [DIMS*COORD_BITS-1:0]   in_coords,
    output logic                              in_ready,
    input  wire logic                         out_free,
    output logic                              res_valid,
    output kmce_pkg::kmce_res_t               res
);
    import kmce_pkg::*;

    localparam int PIDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int CL_W   = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
    localparam int D_W    = (DIMS > 1) ? $clog2(DIMS) : 1;
    localparam int SUM_W  = COORD_BITS + PIDX_W;
    localparam int SQ_W   = 2 * COORD_BITS + 1;
    localparam int DIST_W = 2 * COORD_BITS + 3;
    localparam int PT_W   = DIMS * COORD_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_SEED_RD, S_SEED_WR, S_PASS_CHK, S_PT_RD, S_PT_MUL, S_PT_ACC,
        S_PT_WR, S_UPD, S_UPD_WAIT, S_UPD_END, S_EMIT_RD, S_EMIT_OUT
    } state_t;

    state_t state_reg, state_next;

    logic [PT_W-1:0] point_mem [MAX_POINTS];
    logic [CL_W-1:0] label_mem [MAX_POINTS];
    logic [PT_W-1:0] pt_rd_reg;
    logic [CL_W-1:0] lbl_rd_reg;

    logic signed [COORD_BITS-1:0] center_reg [CLUSTERS][DIMS];
    logic signed [SUM_W-1:0]      sum_reg [CLUSTERS][DIMS];
    logic [CNT_W-1:0]             count_reg [CLUSTERS];

    logic [CNT_W-1:0]  npts_reg, npts_next;
    logic [PASS_W-1:0] pass_reg, pass_next;
    logic [2:0]        nd_reg, nd_next;
    logic [PIDX_W-1:0] p_reg, p_next;
    logic [PIDX_W-1:0] seed_reg, seed_next;
    logic [CL_W-1:0]   c_reg, c_next;
    logic [D_W-1:0]    d_reg, d_next;
    logic [DIST_W-1:0] acc_reg, acc_next;
    logic [DIST_W-1:0] best_reg, best_next;
    logic [CL_W-1:0]   pick_reg, pick_next;
    logic [SQ_W-1:0]   sq_reg;
    logic              moved_reg, moved_next;

    logic                         pt_rd_en;
    logic [PIDX_W-1:0]            pt_rd_addr;
    logic                         last_d, last_c, last_p;
    logic signed [COORD_BITS:0]   diff;
    logic [DIST_W-1:0]            acc_sum;
    logic                         div_start, div_done;
    logic signed [SUM_W-1:0]      div_quot;
    logic signed [COORD_BITS-1:0] mean;
    logic [2:0]                   nd_cfg;

    assign last_d = ({{(3-D_W){1'b0}}, d_reg} == 3'(nd_reg - 3'd1));
    assign last_c = (c_reg == CL_W'(CLUSTERS - 1));
    assign last_p = ({1'b0, p_reg} == CNT_W'(npts_reg - 1'b1));
    assign diff   = (COORD_BITS+1)'(center_reg[c_reg][d_reg])
                  - (COORD_BITS+1)'($signed(pt_rd_reg[d_reg*COORD_BITS +: COORD_BITS]));
    assign acc_sum = acc_reg + DIST_W'(sq_reg);
    assign mean    = div_quot[COORD_BITS-1:0];
    assign nd_cfg  = (cfg.dims_in_use == 3'd0) ? 3'd1
                   : (cfg.dims_in_use > 3'(DIMS)) ? 3'(DIMS) : cfg.dims_in_use;

    kmce_div #(.NUM_BITS(SUM_W), .DEN_BITS(CNT_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (sum_reg[c_reg][d_reg]),
        .den   (count_reg[c_reg]),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        npts_next  = npts_reg;
        pass_next  = pass_reg;
        nd_next    = nd_reg;
        p_next     = p_reg;
        seed_next  = seed_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        acc_next   = acc_reg;
        best_next  = best_reg;
        pick_next  = pick_reg;
        moved_next = moved_reg;
        pt_rd_en   = 1'b0;
        pt_rd_addr = p_reg;
        div_start  = 1'b0;
        in_ready   = (state_reg == S_IDLE);
        res_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_func == FUNC_LOAD)
                    begin
                        if (npts_reg < CNT_W'(MAX_POINTS))
                            npts_next = npts_reg + 1'b1;
                    end
                    else
                    begin
                        pass_next = '0;
                        nd_next   = nd_cfg;
                        c_next    = '0;
                        seed_next = '0;
                        if (npts_reg != '0)
                            state_next = S_SEED_RD;
                    end
                end
            end
            S_SEED_RD:
            begin
                pt_rd_en   = 1'b1;
                pt_rd_addr = seed_reg;
                state_next = S_SEED_WR;
            end
            S_SEED_WR:
            begin
                // wrap the seed index at the point count
                seed_next = ({1'b0, seed_reg} == CNT_W'(npts_reg - 1'b1)) ? '0
                          : seed_reg + 1'b1;
                c_next    = c_reg + 1'b1;
                if (last_c)
                    state_next = S_PASS_CHK;
                else
                    state_next = S_SEED_RD;
            end
            S_PASS_CHK:
            begin
                p_next     = '0;
                moved_next = 1'b0;
                if ((cfg.iteration_mode && pass_reg >= cfg.iteration_limit)
                    || pass_reg == PASS_MAX)
                    state_next = S_EMIT_RD;
                else
                    state_next = S_PT_RD;
            end
            S_PT_RD:
            begin
                pt_rd_en   = 1'b1;
                c_next     = '0;
                d_next     = '0;
                acc_next   = '0;
                state_next = S_PT_MUL;
            end
            S_PT_MUL:
            begin
                state_next = S_PT_ACC;
            end
            S_PT_ACC:
            begin
                if (last_d)
                begin
                    acc_next = '0;
                    d_next   = '0;
                    if (c_reg == '0 || acc_sum < best_reg)
                    begin
                        best_next = acc_sum;
                        pick_next = c_reg;
                    end
                    if (last_c)
                        state_next = S_PT_WR;
                    else
                    begin
                        c_next     = c_reg + 1'b1;
                        state_next = S_PT_MUL;
                    end
                end
                else
                begin
                    acc_next   = acc_sum;
                    d_next     = d_reg + 1'b1;
                    state_next = S_PT_MUL;
                end
            end
            S_PT_WR:
            begin
                c_next = '0;
                d_next = '0;
                if (last_p)
                    state_next = S_UPD;
                else
                begin
                    p_next     = p_reg + 1'b1;
                    state_next = S_PT_RD;
                end
            end
            S_UPD:
            begin
                // skip empty clusters, they keep their center
                if (count_reg[c_reg] == '0)
                begin
                    if (last_c)
                        state_next = S_UPD_END;
                    else
                        c_next = c_reg + 1'b1;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_UPD_WAIT;
                end
            end
            S_UPD_WAIT:
            begin
                if (div_done)
                begin
                    if (mean != center_reg[c_reg][d_reg])
                        moved_next = 1'b1;
                    if (last_d)
                    begin
                        d_next = '0;
                        if (last_c)
                            state_next = S_UPD_END;
                        else
                        begin
                            c_next     = c_reg + 1'b1;
                            state_next = S_UPD;
                        end
                    end
                    else
                    begin
                        d_next     = d_reg + 1'b1;
                        state_next = S_UPD;
                    end
                end
            end
            S_UPD_END:
            begin
                pass_next = pass_reg + 1'b1;
                p_next    = '0;
                if (moved_reg)
                    state_next = S_PASS_CHK;
                else
                    state_next = S_EMIT_RD;
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_OUT;
            end
            S_EMIT_OUT:
            begin
                if (out_free)
                begin
                    res_valid = 1'b1;
                    if (last_p)
                        state_next = S_IDLE;
                    else
                    begin
                        p_next     = p_reg + 1'b1;
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.point_index = 6'(p_reg);
        res.cluster     = (pass_reg == '0) ? 3'd0 : 3'(lbl_rd_reg);
        res.passes_done = pass_reg;
        res.last        = last_p;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            npts_reg  <= '0;
            pass_reg  <= '0;
            nd_reg    <= 3'(DIMS);
            p_reg     <= '0;
            seed_reg  <= '0;
            c_reg     <= '0;
            d_reg     <= '0;
            moved_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            npts_reg  <= npts_next;
            pass_reg  <= pass_next;
            nd_reg    <= nd_next;
            p_reg     <= p_next;
            seed_reg  <= seed_next;
            c_reg     <= c_next;
            d_reg     <= d_next;
            moved_reg <= moved_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        best_reg <= best_next;
        pick_reg <= pick_next;
        sq_reg   <= SQ_W'(diff * diff);
    end

    // point memory: write on load, one synchronous read port
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid && in_func == FUNC_LOAD
            && npts_reg < CNT_W'(MAX_POINTS))
            point_mem[npts_reg[PIDX_W-1:0]] <= in_coords;
        if (pt_rd_en)
            pt_rd_reg <= point_mem[pt_rd_addr];
    end

    // label memory: written at the end of each point, read for emission
    always_ff @(posedge clk)
    begin
        if (state_reg == S_PT_WR)
            label_mem[p_reg] <= pick_reg;
        if (state_reg == S_EMIT_RD)
            lbl_rd_reg <= label_mem[p_reg];
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < CLUSTERS; c++)
        begin
            if (state_reg == S_PASS_CHK)
                count_reg[c] <= '0;
            else if (state_reg == S_PT_WR && pick_reg == CL_W'(c))
                count_reg[c] <= count_reg[c] + 1'b1;
            for (int d = 0; d < DIMS; d++)
            begin
                if (state_reg == S_SEED_WR && c_reg == CL_W'(c))
                    center_reg[c][d] <= $signed(pt_rd_reg[d*COORD_BITS +: COORD_BITS]);
                else if (state_reg == S_UPD_WAIT && div_done && c_reg == CL_W'(c)
                         && d_reg == D_W'(d))
                    center_reg[c][d] <= mean;
                if (state_reg == S_PASS_CHK)
                    sum_reg[c][d] <= '0;
                else if (state_reg == S_PT_WR && pick_reg == CL_W'(c))
                    sum_reg[c][d] <= sum_reg[c][d]
                        + SUM_W'($signed(pt_rd_reg[d*COORD_BITS +: COORD_BITS]));
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/k_means_clustering_engine.sv */
// Top level of the k-means clustering engine: ports, configuration registers, result register.
// A load transaction (tuser 0) stores one point; loads beyond MAX_POINTS are dropped. A run
// transaction (tuser 1) seeds center k from point k mod count, then repeats Lloyd passes until no
// center moves or the limit is hit, and emits one label per point in load order with tlast on
// the final one. Each pass reads the point memory once per point and walks every cluster and used
// coordinate through one shared multiplier, with a multiply state and an accumulate state per
// coordinate; the center update runs a bit-serial divider once per used coordinate of every
// non-empty cluster. Emission reads each label from the label memory, then passes it to the
// output register once that register is free. The input side stays stalled from the run
// transaction until the last label sits in the output register.
`default_nettype none
module k_means_clustering_engine #(
    parameter int CLUSTERS   = 4,
    parameter int DIMS       = 4,
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // coord_0, coord_1, coord_2, coord_3
    input  wire logic        s_axis_tuser,   // func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // point_index, cluster, passes_done, zero pad
    output logic             m_axis_tlast,   // last
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata
);
    import kmce_pkg::*;

    kmce_cfg_t                cfg_reg;
    kmce_res_t                res;
    kmce_res_t                out_reg;
    logic                     out_valid_reg;
    logic                     res_valid;
    logic [DIMS*COORD_BITS-1:0] coords;

    for (genvar d = 0; d < DIMS; d++)
    begin : g_coord
        assign coords[d*COORD_BITS +: COORD_BITS] =
            s_axis_tdata[d*COORD_FIELD_W +: COORD_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dims_in_use     <= 3'd4;
            cfg_reg.iteration_mode  <= 1'b0;
            cfg_reg.iteration_limit <= 16'd16;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_DIMS_IN_USE: cfg_reg.dims_in_use     <= cfg_wdata[2:0];
                REG_ITER_MODE:   cfg_reg.iteration_mode  <= cfg_wdata[0];
                REG_ITER_LIMIT:  cfg_reg.iteration_limit <= cfg_wdata;
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    kmce_core #(
        .CLUSTERS   (CLUSTERS),
        .DIMS       (DIMS),
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_func   (s_axis_tuser),
        .in_coords (coords),
        .in_ready  (s_axis_tready),
        .out_free  (!out_valid_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // hold a result until the transaction completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_valid)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
            out_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_reg.passes_done, out_reg.cluster, out_reg.point_index};
    assign m_axis_tlast  = out_reg.last;

endmodule
`default_nettype wire

/* rtl/k_means_clustering_engine_chk.sv */
// Port-level checker for the k-means clustering engine, bound to the top level.
`default_nettype none
`include "k_means_clustering_engine_assert.svh"
module k_means_clustering_engine_chk #(
    parameter int CLUSTERS = 4
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);
    `KMCE_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed while stalled")
    `KMCE_ASSERT_NEXT(a_busy_in_run, clk, rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast,
        !s_axis_tready, "input accepted before the run finished")
    `KMCE_ASSERT_NOW(a_cluster_range, clk, rst_n, m_axis_tvalid,
        {1'b0, m_axis_tdata[8:6]} < 4'(CLUSTERS), "cluster out of range")
    `KMCE_ASSERT_NOW(a_zero_pass_label, clk, rst_n, m_axis_tvalid && m_axis_tdata[24:9] == 16'd0,
        m_axis_tdata[8:6] == 3'd0, "nonzero label without a pass")

endmodule

bind k_means_clustering_engine k_means_clustering_engine_chk #(.CLUSTERS(CLUSTERS)) u_chk (.*);
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the k-means clustering engine: loads, runs and label checks.
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
    import kmce_pkg::*;

    localparam int NPTS      = 64;
    localparam int NCLUST    = 4;
    localparam int NDIM      = 4;
    localparam int MAX_CYCLE = 30_000_000;

    // Predicts the labels of each run and checks the emitted ones in order.
    class label_scoreboard;
        logic signed [15:0] pts [NPTS][NDIM];
        int                 npts;
        int                 ctr [NCLUST][NDIM];
        bit [2:0]           lbl [NPTS];
        bit [2:0]           dims_reg = 3'd4;
        bit                 mode_reg = 1'b0;
        bit [15:0]          limit_reg = 16'd16;
        kmce_res_t          exp_labels [$];
        int                 errors;
        int                 checked;

        task report(string what);
            errors++;
            $display("MISMATCH at %0t: %s", $realtime, what);
        endtask

        function void write_reg(kmce_reg_e idx, bit [15:0] val);
            case (idx)
                REG_DIMS_IN_USE: dims_reg  = val[2:0];
                REG_ITER_MODE:   mode_reg  = val[0];
                REG_ITER_LIMIT:  limit_reg = val;
                default: ;
            endcase
        endfunction

        // One Lloyd pass; returns 1 when any center moved.
        function bit lloyd_pass(int nd);
            longint sums [NCLUST][NDIM];
            int     cnt [NCLUST];
            longint best;
            longint sq_dist;
            longint diff;
            int     pick;
            int     mean;
            bit     moved;
            moved = 0;
            foreach (cnt[c]) cnt[c] = 0;
            foreach (sums[c, d]) sums[c][d] = 0;
            for (int p = 0; p < npts; p++)
            begin
                best = 0;
                pick = 0;
                for (int c = 0; c < NCLUST; c++)
                begin
                    sq_dist = 0;
                    for (int d = 0; d < nd; d++)
                    begin
                        diff = longint'(ctr[c][d]) - longint'(pts[p][d]);
                        sq_dist += diff * diff;
                    end
                    if (c == 0 || sq_dist < best)
                    begin
                        best = sq_dist;
                        pick = c;
                    end
                end
                lbl[p] = pick[2:0];
                cnt[pick]++;
                for (int d = 0; d < nd; d++)
                    sums[pick][d] += longint'(pts[p][d]);
            end
            for (int c = 0; c < NCLUST; c++)
            begin
                if (cnt[c] == 0)
                    continue;
                for (int d = 0; d < nd; d++)
                begin
                    mean = int'(sums[c][d] / longint'(cnt[c]));
                    if (mean != ctr[c][d])
                    begin
                        ctr[c][d] = mean;
                        moved = 1;
                    end
                end
            end
            return moved;
        endfunction

        function void cluster_run();
            int        nd;
            int        passes;
            kmce_res_t r;
            passes = 0;
            foreach (lbl[p]) lbl[p] = 3'd0;
            if (npts == 0)
                return;
            nd = (dims_reg < 1) ? 1 : (dims_reg > NDIM) ? NDIM : int'(dims_reg);
            foreach (ctr[c, d]) ctr[c][d] = int'(pts[c % npts][d]);
            forever
            begin
                if (mode_reg && passes >= int'(limit_reg))
                    break;
                if (passes >= int'(PASS_MAX))
                    break;
                passes++;
                if (!lloyd_pass(nd))
                    break;
            end
            for (int p = 0; p < npts; p++)
            begin
                r.point_index = p[5:0];
                r.cluster     = lbl[p];
                r.passes_done = passes[15:0];
                r.last        = (p + 1 == npts);
                exp_labels.push_back(r);
            end
        endfunction

        function void note_item(kmce_func_e fn, logic [63:0] data);
            if (fn == FUNC_RUN)
                cluster_run();
            else if (npts < NPTS)
            begin
                for (int d = 0; d < NDIM; d++)
                    pts[npts][d] = data[d*16 +: 16];
                npts++;
            end
        endfunction

        task check_label(kmce_res_t got);
            kmce_res_t want;
            if (exp_labels.size() == 0)
            begin
                report($sformatf("unexpected label for point %0d", got.point_index));
                return;
            end
            want = exp_labels.pop_front();
            checked++;
            if (got.point_index !== want.point_index)
                report($sformatf("point_index %0d, want %0d", got.point_index, want.point_index));
            if (got.cluster !== want.cluster)
                report($sformatf("point %0d cluster %0d, want %0d",
                                 want.point_index, got.cluster, want.cluster));
            if (got.passes_done !== want.passes_done)
                report($sformatf("point %0d passes_done %0d, want %0d",
                                 want.point_index, got.passes_done, want.passes_done));
            if (got.last !== want.last)
                report($sformatf("point %0d last %0b, want %0b",
                                 want.point_index, got.last, want.last));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [15:0] cfg_wdata;

    label_scoreboard sb;
    int              send_idle_pct;
    int              stall_pct;
    int              cycles;
    int              n_loads;
    int              n_runs;
    logic [15:0]     bases [4];

    k_means_clustering_engine u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYCLE)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        kmce_res_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.point_index = m_axis_tdata[5:0];
            got.cluster     = m_axis_tdata[8:6];
            got.passes_done = m_axis_tdata[24:9];
            got.last        = m_axis_tlast;
            sb.check_label(got);
        end
    end

    task send_item(kmce_func_e fn, logic [63:0] data);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(99) < send_idle_pct)
                s_axis_tvalid <= 1'b0;
            else
                break;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= data;
        forever
        begin
            @(posedge clk);
            if (s_axis_tready)
                break;
        end
        sb.note_item(fn, data);
        if (fn == FUNC_RUN)
            n_runs++;
        else
            n_loads++;
    endtask

    // Drop valid and hold until every predicted label has come out.
    task drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.exp_labels.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task set_config(bit [2:0] dims, bit mode, bit [15:0] limit);
        kmce_reg_e   idx [3];
        logic [15:0] val [3];
        idx = '{REG_DIMS_IN_USE, REG_ITER_MODE, REG_ITER_LIMIT};
        val = '{{13'd0, dims}, {15'd0, mode}, limit};
        drain();
        for (int i = 0; i < 3; i++)
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_addr  <= idx[i];
            cfg_wdata <= val[i];
            sb.write_reg(idx[i], val[i]);
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function logic [15:0] rand_coord();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
            default: return bases[$urandom_range(3)] + 16'($urandom_range(64)) - 16'd32;
        endcase
    endfunction

    task rand_phase(bit [2:0] dims, bit mode, bit [15:0] limit, int idle_sel,
                    int n_items, int run_pct);
        logic [63:0] data;
        set_config(dims, mode, limit);
        send_idle_pct = (idle_sel == 1) ? 71 : (idle_sel == 3) ? 12 : 0;
        stall_pct     = (idle_sel == 2) ? 71 : (idle_sel == 3) ? 12 : 0;
        for (int i = 0; i < n_items; i++)
        begin
            for (int d = 0; d < NDIM; d++)
                data[d*16 +: 16] = rand_coord();
            if ($urandom_range(99) < run_pct)
                send_item(FUNC_RUN, data);
            else
                send_item(FUNC_LOAD, data);
        end
    endtask

    initial
    begin
        sb            = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FUNC_LOAD;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = REG_DIMS_IN_USE;
        cfg_wdata     = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        foreach (bases[i]) bases[i] = 16'($urandom);
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty run, single point, fewer points than centers, ties.
        set_config(3'd4, 1'b0, 16'd16);
        send_item(FUNC_RUN, 64'd0);
        send_item(FUNC_LOAD, {16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF});
        send_item(FUNC_RUN, 64'd0);
        send_item(FUNC_LOAD, {16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000});
        send_item(FUNC_RUN, 64'd0);
        send_item(FUNC_LOAD, 64'd0);
        send_item(FUNC_LOAD, 64'd0);
        send_item(FUNC_LOAD, {4{16'd100}});
        send_item(FUNC_RUN, 64'd0);
        set_config(3'd4, 1'b1, 16'd0);
        send_item(FUNC_RUN, 64'd0);
        set_config(3'd0, 1'b1, 16'd1);
        send_item(FUNC_LOAD, {16'd4, 16'd3, 16'd2, 16'd1});
        send_item(FUNC_RUN, 64'd0);
        set_config(3'd6, 1'b1, 16'hFFFF);
        send_item(FUNC_RUN, 64'd0);

        rand_phase(3'd4, 1'b1, 16'd3,     0, 60, 8);
        rand_phase(3'd1, 1'b0, 16'd0,     1, 25, 10);
        rand_phase(3'd2, 1'b1, 16'hFFFF,  2, 25, 10);
        rand_phase(3'd7, 1'b1, 16'd1,     3, 50, 20);
        drain();
        rand_phase(3'd3, 1'b1, 16'd0,     0, 60, 30);
        rand_phase(3'd0, 1'b1, 16'd2,     1, 60, 20);
        rand_phase(3'd5, 1'b1, 16'd4,     2, 60, 20);
        rand_phase(3'd4, 1'b0, 16'd7,     3, 20, 10);
        rand_phase(3'd2, 1'b1, 16'd1,     0, 87, 20);

        drain();
        repeat (200) @(posedge clk);
        $display("covered %0d loads and %0d runs, %0d labels checked",
                 n_loads, n_runs, sb.checked);
        if (sb.errors == 0 && sb.exp_labels.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end
endmodule

`default_nettype wire

/* k_means_clustering_engine.f */
+incdir+rtl
rtl/kmce_pkg.sv
rtl/kmce_div.sv
rtl/kmce_core.sv
rtl/k_means_clustering_engine.sv
rtl/k_means_clustering_engine_chk.sv
tb/tb_top.sv
